FILE: src/sfa_pkg.sv
// Shared types and constants of the segment frame allocator.
package sfa_pkg;

   localparam int FRAMES    = 256;
   localparam int PROCESSES = 8;
   localparam int SEGMENTS  = 8;
   localparam int VPAGES    = 64;

   localparam int FRAME_W = $clog2(FRAMES);
   localparam int COUNT_W = 9;
   localparam int PID_W   = 3;
   localparam int SEG_W   = 3;
   localparam int PAGE_W  = $clog2(VPAGES);
   localparam int LIMIT_W = 7;
   localparam int RANK_W  = SEG_W;
   localparam int SCAN_W  = SEG_W + 1;

   localparam int PT_DEPTH = PROCESSES * VPAGES;
   localparam int SD_DEPTH = PROCESSES * SEGMENTS;
   localparam int PT_AW    = $clog2(PT_DEPTH);

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_ADD      = 2'd0;
   localparam opcode_type OP_DESTROY  = 2'd1;
   localparam opcode_type OP_DEST_PROC = 2'd2;
   localparam opcode_type OP_READ     = 2'd3;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_IN_USE    = 3'd1;
   localparam status_type ST_NO_FRAMES = 3'd2;
   localparam status_type ST_OVERLAP   = 3'd3;
   localparam status_type ST_RANGE     = 3'd4;
   localparam status_type ST_INVALID   = 3'd5;

   typedef struct packed {
      logic [LIMIT_W-1:0] limit;
      logic [PAGE_W-1:0]  base;
      logic [SEG_W-1:0]   seg;
      logic [PID_W-1:0]   pid;
      opcode_type         opcode;
   } req_item_type;

   typedef struct packed {
      logic               valid;
      status_type         status;
      logic [COUNT_W-1:0] free_frames;
   } result_type;

   typedef struct packed {
      logic               valid;
      logic [FRAME_W-1:0] frame;
   } page_entry_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  base;
      logic [LIMIT_W-1:0] limit;
      logic [RANK_W-1:0]  rank;
   } seg_desc_type;

endpackage

FILE: src/sfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/sfa_ctrl.sv
// Sequencer that walks page table, free queue and descriptors.
module sfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  sfa_pkg::req_item_type item,
   output logic                 idle,
   output sfa_pkg::result_type  result
);
   import sfa_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_A_DESC, S_A_CHK, S_A_CHKW, S_A_POP, S_A_PUT, S_A_DESCW,
      S_D_DESC, S_D_DESCR, S_D_PG, S_D_PGW, S_D_RK, S_D_RKW, S_D_END,
      S_P_RD, S_P_CHK, S_DONE
   } state_type;

   state_type            state_ff;
   logic [PT_AW-1:0]     clr_ff;
   logic [PID_W-1:0]     pid_ff;
   logic [SEG_W-1:0]     sid_ff;
   logic [PAGE_W-1:0]    base_ff;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [PAGE_W-1:0]    page_ff;
   logic [LIMIT_W-1:0]   rem_ff;
   logic [RANK_W-1:0]    drank_ff;
   logic [SCAN_W-1:0]    scan_ff;
   logic [SCAN_W-1:0]    k_ff;
   logic [SCAN_W-1:0]    total_ff;
   logic                 proc_ff;
   logic [FRAME_W-1:0]   head_ff;
   logic [FRAME_W-1:0]   tail_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [FRAMES-1:0]    fq_wr_ff;
   logic [SD_DEPTH-1:0]  vld_ff;
   status_type           status_ff;

   // memory ports
   logic                 pt_wr_en, pt_rd_en;
   logic [PT_AW-1:0]     pt_wr_addr;
   page_entry_type       pt_wr_data, pt_rd_data;
   logic                 fq_wr_en, fq_rd_en;
   logic [FRAME_W-1:0]   fq_rd_data;
   logic                 sd_wr_en, sd_rd_en;
   logic [PID_W+SEG_W-1:0] sd_wr_addr, sd_rd_addr;
   seg_desc_type         sd_wr_data, sd_rd_data;

   logic [PT_AW-1:0]       pt_addr;
   logic [PID_W+SEG_W-1:0] desc_idx, scan_idx;
   logic [SEGMENTS-1:0]    row_vld, in_row_vld;
   logic [FRAME_W-1:0]     pop_frame;
   logic                   push_ok;

   assign pt_addr    = {pid_ff, page_ff};
   assign desc_idx   = {pid_ff, sid_ff};
   assign scan_idx   = {pid_ff, scan_ff[SEG_W-1:0]};
   assign row_vld    = vld_ff[pid_ff*SEGMENTS +: SEGMENTS];
   assign in_row_vld = vld_ff[item.pid*SEGMENTS +: SEGMENTS];
   // unwritten queue slots stand for their reset frame, the slot index
   assign pop_frame  = (count_ff == '0) ? '0 :
                       (fq_wr_ff[head_ff] ? fq_rd_data : head_ff);
   assign push_ok    = pt_rd_data.valid && (count_ff < COUNT_W'(FRAMES));

   always_comb begin
      pt_wr_en   = 1'b0;
      pt_wr_addr = pt_addr;
      pt_wr_data = '0;
      pt_rd_en   = (state_ff == S_A_CHK) || (state_ff == S_D_PG);
      fq_rd_en   = (state_ff == S_A_POP);
      fq_wr_en   = (state_ff == S_D_PGW) && push_ok;
      sd_rd_en   = 1'b0;
      sd_rd_addr = scan_idx;
      sd_wr_en   = 1'b0;
      sd_wr_addr = desc_idx;
      sd_wr_data = '0;
      unique case (state_ff)
         S_CLEAR: begin
            pt_wr_en   = 1'b1;
            pt_wr_addr = clr_ff;
         end
         S_A_PUT: begin
            pt_wr_en   = 1'b1;
            pt_wr_data = '{valid: 1'b1, frame: pop_frame};
         end
         S_D_PGW: pt_wr_en = 1'b1;
         S_A_DESCW: begin
            sd_wr_en   = 1'b1;
            sd_wr_data = '{base: base_ff, limit: limit_ff,
                           rank: RANK_W'($countones(row_vld))};
         end
         S_D_DESC: begin
            sd_rd_en   = 1'b1;
            sd_rd_addr = desc_idx;
         end
         S_D_RK, S_P_RD: sd_rd_en = 1'b1;
         S_D_RKW: begin
            sd_wr_addr = scan_idx;
            sd_wr_data = sd_rd_data;
            sd_wr_data.rank = sd_rd_data.rank - 1'b1;
            sd_wr_en   = vld_ff[scan_idx] && (sd_rd_data.rank > drank_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= COUNT_W'(FRAMES);
         fq_wr_ff  <= '0;
         vld_ff    <= '0;
         status_ff <= ST_OK;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == PT_AW'(PT_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  pid_ff   <= item.pid;
                  sid_ff   <= item.seg;
                  base_ff  <= item.base;
                  limit_ff <= item.limit;
                  proc_ff  <= 1'b0;
                  unique case (item.opcode)
                     OP_ADD:     state_ff <= S_A_DESC;
                     OP_DESTROY: state_ff <= S_D_DESC;
                     OP_DEST_PROC: begin
                        proc_ff  <= 1'b1;
                        k_ff     <= '0;
                        scan_ff  <= '0;
                        total_ff <= SCAN_W'($countones(in_row_vld));
                        state_ff <= S_P_RD;
                     end
                     OP_READ: begin
                        status_ff <= ST_OK;
                        state_ff  <= S_DONE;
                     end
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_A_DESC: begin
               page_ff <= base_ff;
               rem_ff  <= limit_ff;
               priority if (vld_ff[desc_idx]) begin
                  status_ff <= ST_IN_USE;
                  state_ff  <= S_DONE;
               end else if (COUNT_W'(limit_ff) > count_ff) begin
                  status_ff <= ST_NO_FRAMES;
                  state_ff  <= S_DONE;
               end else if ((8'(base_ff) + 8'(limit_ff)) > 8'(VPAGES)) begin
                  status_ff <= ST_RANGE;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_A_CHK;
               end
            end
            S_A_CHK: begin
               if (rem_ff == '0) begin
                  page_ff  <= base_ff;
                  rem_ff   <= limit_ff;
                  state_ff <= S_A_POP;
               end else begin
                  state_ff <= S_A_CHKW;
               end
            end
            S_A_CHKW: begin
               if (pt_rd_data.valid) begin
                  status_ff <= ST_OVERLAP;
                  state_ff  <= S_DONE;
               end else begin
                  page_ff  <= page_ff + 1'b1;
                  rem_ff   <= rem_ff - 1'b1;
                  state_ff <= S_A_CHK;
               end
            end
            S_A_POP: state_ff <= (rem_ff == '0) ? S_A_DESCW : S_A_PUT;
            S_A_PUT: begin
               if (count_ff != '0) begin
                  head_ff  <= (head_ff == FRAME_W'(FRAMES - 1)) ? '0 : head_ff + 1'b1;
                  count_ff <= count_ff - 1'b1;
               end
               page_ff  <= page_ff + 1'b1;
               rem_ff   <= rem_ff - 1'b1;
               state_ff <= S_A_POP;
            end
            S_A_DESCW: begin
               vld_ff[desc_idx] <= 1'b1;
               status_ff        <= ST_OK;
               state_ff         <= S_DONE;
            end
            S_D_DESC: begin
               if (!vld_ff[desc_idx]) begin
                  status_ff <= ST_INVALID;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_D_DESCR;
               end
            end
            S_D_DESCR: begin
               page_ff  <= sd_rd_data.base;
               rem_ff   <= sd_rd_data.limit;
               drank_ff <= sd_rd_data.rank;
               state_ff <= S_D_PG;
            end
            S_D_PG: begin
               if (rem_ff == '0) begin
                  scan_ff  <= '0;
                  state_ff <= proc_ff ? S_D_END : S_D_RK;
               end else begin
                  state_ff <= S_D_PGW;
               end
            end
            S_D_PGW: begin
               if (push_ok) begin
                  fq_wr_ff[tail_ff] <= 1'b1;
                  tail_ff  <= (tail_ff == FRAME_W'(FRAMES - 1)) ? '0 : tail_ff + 1'b1;
                  count_ff <= count_ff + 1'b1;
               end
               page_ff  <= page_ff + 1'b1;
               rem_ff   <= rem_ff - 1'b1;
               state_ff <= S_D_PG;
            end
            S_D_RK: state_ff <= (scan_ff == SCAN_W'(SEGMENTS)) ? S_D_END : S_D_RKW;
            S_D_RKW: begin
               scan_ff  <= scan_ff + 1'b1;
               state_ff <= S_D_RK;
            end
            S_D_END: begin
               vld_ff[desc_idx] <= 1'b0;
               if (proc_ff) begin
                  k_ff     <= k_ff + 1'b1;
                  scan_ff  <= '0;
                  state_ff <= S_P_RD;
               end else begin
                  status_ff <= ST_OK;
                  state_ff  <= S_DONE;
               end
            end
            S_P_RD: begin
               priority if (k_ff == total_ff) begin
                  vld_ff[pid_ff*SEGMENTS +: SEGMENTS] <= '0;
                  status_ff <= ST_OK;
                  state_ff  <= S_DONE;
               end else if (scan_ff == SCAN_W'(SEGMENTS)) begin
                  k_ff    <= k_ff + 1'b1;
                  scan_ff <= '0;
               end else begin
                  state_ff <= S_P_CHK;
               end
            end
            S_P_CHK: begin
               if (vld_ff[scan_idx] && (sd_rd_data.rank == k_ff[RANK_W-1:0])) begin
                  sid_ff   <= scan_ff[SEG_W-1:0];
                  page_ff  <= sd_rd_data.base;
                  rem_ff   <= sd_rd_data.limit;
                  state_ff <= S_D_PG;
               end else begin
                  scan_ff  <= scan_ff + 1'b1;
                  state_ff <= S_P_RD;
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign idle   = (state_ff == S_IDLE);
   assign result = '{valid: (state_ff == S_DONE), status: status_ff,
                     free_frames: count_ff};

   sfa_ram #(.WIDTH($bits(page_entry_type)), .DEPTH(PT_DEPTH)) u_page_ram (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_en   (pt_rd_en),
      .rd_addr (pt_addr),
      .rd_data (pt_rd_data)
   );

   sfa_ram #(.WIDTH(FRAME_W), .DEPTH(FRAMES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (fq_wr_en),
      .wr_addr (tail_ff),
      .wr_data (pt_rd_data.frame),
      .rd_en   (fq_rd_en),
      .rd_addr (head_ff),
      .rd_data (fq_rd_data)
   );

   sfa_ram #(.WIDTH($bits(seg_desc_type)), .DEPTH(SD_DEPTH)) u_desc_ram (
      .clock   (clock),
      .wr_en   (sd_wr_en),
      .wr_addr (sd_wr_addr),
      .wr_data (sd_wr_data),
      .rd_en   (sd_rd_en),
      .rd_addr (sd_rd_addr),
      .rd_data (sd_rd_data)
   );
endmodule

FILE: src/segment_frame_allocator.sv
// Top level of the segment frame allocator: stream ports and result register.
//
// Hands out physical frames to the segments of 8 processes (8 descriptors and
// a 64-page table each) from a 256-entry circular free queue. One request word
// gives exactly one response word: status and the free frame count after the
// operation. After reset the page table is cleared by a sweep, one entry a
// cycle, before the first request word is taken. Work is done by a sequencer
// that steps through page-table, queue and descriptor accesses: add runs an
// overlap check pass, then an allocation pass, each a read and a use per
// page; destroy walks its pages, each a read and a use, then updates the
// ranks of the process's descriptors; destroy-process is the sum of its
// segment walks plus its descriptor scans; read-count only returns the count.
// The block takes one request at a time and accepts none while a response is
// still waiting on rsp_.
module segment_frame_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // pid[2:0], seg[5:3], base[11:6], limit[18:12]
   input  logic [1:0]  req_tuser,  // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // status[2:0], free_frames[11:3]
);
   import sfa_pkg::*;

   req_item_type       item;
   result_type         result;
   logic               idle;
   logic               start;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [COUNT_W-1:0] rsp_free_ff;

   assign item = '{limit: req_tdata[18:12], base: req_tdata[11:6],
                   seg: req_tdata[5:3], pid: req_tdata[2:0], opcode: req_tuser};

   // one word in flight: wait for the sequencer and an empty result register
   assign req_tready = idle && !rsp_valid_ff;
   assign start      = req_tvalid && req_tready;

   sfa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .item   (item),
      .idle   (idle),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (result.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (result.valid) begin
         rsp_status_ff <= result.status;
         rsp_free_ff   <= result.free_frames;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_free_ff, rsp_status_ff};
endmodule

FILE: tb/sv/tb_segment_frame_allocator.sv
// Self-checking testbench of the segment frame allocator: directed cases and random traffic with a scoreboard.
`timescale 1ns / 100ps

module tb_segment_frame_allocator;
   import sfa_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // pid[2:0], seg[5:3], base[11:6], limit[18:12]
   logic [1:0]  req_tuser;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // status[2:0], free_frames[11:3]

   // Expected response word.
   typedef struct {
      status_type         status;
      logic [COUNT_W-1:0] free_frames;
   } rsp_word_type;

   // Predicts the allocator: free queue, page tables, descriptors with ranks.
   class frame_scoreboard;
      logic [FRAME_W-1:0] free_ring [FRAMES];
      int                 ring_head;
      int                 ring_tail;
      int                 frames_free;
      bit                 page_used [PT_DEPTH];
      logic [FRAME_W-1:0] page_frame [PT_DEPTH];
      bit                 seg_used [SD_DEPTH];
      int                 seg_base [SD_DEPTH];
      int                 seg_limit [SD_DEPTH];
      int                 seg_rank [SD_DEPTH];
      rsp_word_type       pending_rsp [$];
      int                 mismatches;

      function void clear();
         for (int i = 0; i < FRAMES; i++) free_ring[i] = FRAME_W'(i);
         ring_head = 0;
         ring_tail = 0;
         frames_free = FRAMES;
         for (int i = 0; i < PT_DEPTH; i++) begin
            page_used[i] = 0;
            page_frame[i] = '0;
         end
         for (int i = 0; i < SD_DEPTH; i++) begin
            seg_used[i] = 0;
            seg_base[i] = 0;
            seg_limit[i] = 0;
            seg_rank[i] = 0;
         end
         pending_rsp.delete();
         mismatches = 0;
      endfunction

      function logic [FRAME_W-1:0] take_frame();
         logic [FRAME_W-1:0] f;
         if (frames_free == 0) return '0;
         f = free_ring[ring_head];
         ring_head = (ring_head + 1) % FRAMES;
         frames_free--;
         return f;
      endfunction

      function void give_frame(logic [FRAME_W-1:0] f);
         if (frames_free >= FRAMES) return;
         free_ring[ring_tail] = f;
         ring_tail = (ring_tail + 1) % FRAMES;
         frames_free++;
      endfunction

      function status_type add_seg(int pid, int sid, int base, int lim);
         int d;
         int live;
         d = pid * SEGMENTS + sid;
         live = 0;
         if (seg_used[d]) return ST_IN_USE;
         if (lim > frames_free) return ST_NO_FRAMES;
         if (base + lim > VPAGES) return ST_RANGE;
         for (int p = base; p < base + lim; p++)
            if (page_used[pid * VPAGES + p]) return ST_OVERLAP;
         for (int p = base; p < base + lim; p++) begin
            page_frame[pid * VPAGES + p] = take_frame();
            page_used[pid * VPAGES + p] = 1;
         end
         for (int s = 0; s < SEGMENTS; s++)
            if (seg_used[pid * SEGMENTS + s]) live++;
         seg_used[d] = 1;
         seg_base[d] = base;
         seg_limit[d] = lim;
         seg_rank[d] = live;
         return ST_OK;
      endfunction

      function status_type drop_seg(int pid, int sid);
         int d;
         int stop;
         d = pid * SEGMENTS + sid;
         if (!seg_used[d]) return ST_INVALID;
         stop = seg_base[d] + seg_limit[d];
         if (stop > VPAGES) stop = VPAGES;
         for (int p = seg_base[d]; p < stop; p++) begin
            if (page_used[pid * VPAGES + p]) give_frame(page_frame[pid * VPAGES + p]);
            page_used[pid * VPAGES + p] = 0;
            page_frame[pid * VPAGES + p] = '0;
         end
         for (int s = 0; s < SEGMENTS; s++)
            if (seg_used[pid * SEGMENTS + s] && seg_rank[pid * SEGMENTS + s] > seg_rank[d])
               seg_rank[pid * SEGMENTS + s]--;
         seg_used[d] = 0;
         seg_base[d] = 0;
         seg_limit[d] = 0;
         seg_rank[d] = 0;
         return ST_OK;
      endfunction

      // Oldest segment always holds rank zero.
      function void drop_process(int pid);
         for (int r = 0; r < SEGMENTS; r++)
            for (int s = 0; s < SEGMENTS; s++)
               if (seg_used[pid * SEGMENTS + s] && seg_rank[pid * SEGMENTS + s] == 0) begin
                  void'(drop_seg(pid, s));
                  break;
               end
      endfunction

      function void note_request(req_item_type w);
         rsp_word_type r;
         r.status = ST_OK;
         case (w.opcode)
            OP_ADD: begin
               r.status = add_seg(int'(w.pid), int'(w.seg), int'(w.base), int'(w.limit));
            end
            OP_DESTROY: begin
               r.status = drop_seg(int'(w.pid), int'(w.seg));
            end
            OP_DEST_PROC: begin
               drop_process(int'(w.pid));
            end
            default: begin
            end
         endcase
         r.free_frames = frames_free[COUNT_W-1:0];
         pending_rsp.push_back(r);
      endfunction

      function void check_response(logic [15:0] data);
         rsp_word_type e;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", data);
            return;
         end
         e = pending_rsp.pop_front();
         if (data[2:0] !== e.status || data[11:3] !== e.free_frames) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: status exp %0d got %0d, free exp %0d got %0d",
                        e.status, data[2:0], e.free_frames, data[11:3]);
         end
      endfunction
   endclass

   frame_scoreboard board;
   int              rsp_seen;

   segment_frame_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Sends one request word after a random gap; waits for the handshake.
   // Returns at the falling edge after the accept with tvalid still high.
   task automatic send_word(input opcode_type op, input int pid, input int sid,
                            input int base, input int lim);
      req_item_type w;
      int           gap;
      w.opcode = op;
      w.pid = PID_W'(pid);
      w.seg = SEG_W'(sid);
      w.base = PAGE_W'(base);
      w.limit = LIMIT_W'(lim);
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;   // back-to-back stretches
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, w.limit, w.base, w.seg, w.pid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(w);
      @(negedge clock);
   endtask

   // Response side: random wait before each word is taken.
   initial begin
      int wait_n;
      rsp_tready = 0;
      rsp_seen = 0;
      @(negedge clock);
      forever begin
         wait_n = $urandom_range(0, 6);
         if (wait_n != 0) begin
            rsp_tready <= 0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_response(rsp_tdata);
         rsp_seen++;
         @(negedge clock);
      end
   end

   // Stimulus: directed corner cases, then random traffic.
   initial begin
      int op;
      int base;
      int lim;
      board = new();
      board.clear();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = OP_READ;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_word(OP_READ, 0, 0, 0, 0);
      send_word(OP_ADD, 0, 0, 0, 64);        // full page table
      send_word(OP_ADD, 0, 0, 0, 1);         // descriptor in use
      send_word(OP_ADD, 0, 1, 10, 1);        // overlap
      send_word(OP_ADD, 1, 0, 63, 2);        // out of range
      send_word(OP_ADD, 1, 7, 63, 1);        // last page
      send_word(OP_ADD, 2, 0, 0, 0);         // empty segment
      send_word(OP_ADD, 3, 0, 0, 64);
      send_word(OP_ADD, 4, 0, 0, 64);
      send_word(OP_ADD, 5, 0, 0, 64);        // not enough frames
      send_word(OP_ADD, 5, 1, 0, 127);       // limit beyond page count
      send_word(OP_DESTROY, 6, 6, 0, 0);     // invalid descriptor
      send_word(OP_DESTROY, 0, 0, 0, 0);
      send_word(OP_DEST_PROC, 7, 0, 0, 0);   // process with no segments
      send_word(OP_DEST_PROC, 3, 0, 0, 0);
      send_word(OP_DEST_PROC, 4, 0, 0, 0);
      send_word(OP_DEST_PROC, 1, 0, 0, 0);
      send_word(OP_DEST_PROC, 2, 0, 0, 0);
      send_word(OP_READ, 7, 7, 63, 127);

      for (int n = 0; n < 1130; n++) begin
         op = $urandom_range(0, 9);
         if (op < 5) begin
            // mostly short segments to keep frames flowing
            lim = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
            base = $urandom_range(0, 63);
            send_word(OP_ADD, $urandom_range(0, 7), $urandom_range(0, 7), base, lim);
         end else if (op < 8) begin
            send_word(OP_DESTROY, $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 63), $urandom_range(0, 127));
         end else if (op == 8) begin
            send_word(OP_DEST_PROC, $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 63), $urandom_range(0, 127));
         end else begin
            send_word(OP_READ, $urandom_range(0, 7), $urandom_range(0, 7),
                      $urandom_range(0, 63), $urandom_range(0, 127));
         end
      end
      req_tvalid <= 0;

      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.mismatches == 0 && board.pending_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // A run of about 1150 words is far below this bound.
   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: segment_frame_allocator.f
src/sfa_pkg.sv
src/sfa_ram.sv
src/sfa_ctrl.sv
src/segment_frame_allocator.sv
tb/sv/tb_segment_frame_allocator.sv
